// ----- rtl/apcl_pkg.sv -----
// Shared types, constants and register indexes for the arm position control loop.
package apcl_pkg;

    localparam int unsigned PosW  = 24;
    localparam int unsigned TimeW = 32;
    localparam int unsigned SpdW  = 32;
    localparam int unsigned CfgW  = 24;
    localparam int unsigned IdxW  = 3;
    localparam int unsigned DefDivW = 48;

    localparam logic [IdxW-1:0] REG_LOWER   = 3'd0;
    localparam logic [IdxW-1:0] REG_UPPER   = 3'd1;
    localparam logic [IdxW-1:0] REG_BAND    = 3'd2;
    localparam logic [IdxW-1:0] REG_HOLD_EN = 3'd3;
    localparam logic [IdxW-1:0] REG_HOLD    = 3'd4;
    localparam logic [IdxW-1:0] REG_MINMOVE = 3'd5;
    localparam logic [IdxW-1:0] REG_MAXMOVE = 3'd6;
    localparam logic [IdxW-1:0] REG_GAIN    = 3'd7;

    typedef struct packed {
        logic signed [PosW-1:0] position_cd;
        logic                   sensor_fault;
        logic signed [PosW-1:0] target_cd;
        logic signed [7:0]      manual_power;
        logic                   manual_coast;
        logic [TimeW-1:0]       time_ms;
    } t_in_beat;

    typedef struct packed {
        logic signed [7:0] motor_power;
        logic              brake_hold;
    } t_out_beat;

    typedef struct packed {
        logic signed [PosW-1:0] lower;
        logic signed [PosW-1:0] upper;
        logic [15:0]            band;
        logic                   hold_en;
        logic [6:0]             hold;
        logic [6:0]             minmove;
        logic [6:0]             maxmove;
        logic [6:0]             gain;
    } t_cfg;

    // divider request/response between sequencer and serial divider
    typedef struct packed {
        logic start;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_rsp;

endpackage

// ----- rtl/apcl_if.sv -----
// Valid/ready channel interface carrying one payload beat.
interface apcl_if #(parameter type t_payload = logic) ();
    logic     valid;
    logic     ready;
    t_payload payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/apcl_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle, rounding half away from zero.
module apcl_div #(
    parameter int unsigned DivW = apcl_pkg::DefDivW
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  apcl_pkg::t_div_req      i_req,
    input  logic signed [DivW-1:0]  i_num,
    input  logic [DivW-1:0]         i_den,
    output apcl_pkg::t_div_rsp      o_rsp,
    output logic signed [DivW-1:0]  o_quo
);
    import apcl_pkg::*;

    localparam int unsigned CntW = $clog2(DivW + 1);

    logic [DivW-1:0]  r_q, n_q;
    logic [DivW:0]    r_rem, n_rem;
    logic [DivW-1:0]  r_den;
    logic             r_neg;
    logic [CntW-1:0]  r_cnt, n_cnt;
    logic             r_busy, r_done;
    logic [DivW:0]    w_trial;
    logic [DivW:0]    w_twice;
    logic [DivW-1:0]  w_mag;
    logic [DivW-1:0]  w_qr;

    assign w_trial = {r_rem[DivW-1:0], r_q[DivW-1]} - {1'b0, r_den};
    assign w_mag   = i_num[DivW-1] ? DivW'(-i_num) : DivW'(i_num);

    always_comb begin
        n_q   = r_q;
        n_rem = r_rem;
        n_cnt = r_cnt;
        if (r_busy) begin
            if (!w_trial[DivW]) begin
                n_rem = w_trial;
                n_q   = {r_q[DivW-2:0], 1'b1};
            end else begin
                n_rem = {r_rem[DivW-1:0], r_q[DivW-1]};
                n_q   = {r_q[DivW-2:0], 1'b0};
            end
            n_cnt = r_cnt - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CntW'(DivW);
            end else if (r_busy) begin
                r_cnt <= n_cnt;
                if (r_cnt == CntW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= w_mag;
            r_rem <= '0;
            r_den <= i_den;
            r_neg <= i_num[DivW-1];
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    // round: bump when 2*rem >= den
    assign w_twice = {r_rem[DivW-1:0], 1'b0};
    assign w_qr    = r_q + DivW'(w_twice >= {1'b0, r_den});
    assign o_quo   = r_neg ? -$signed(w_qr) : $signed(w_qr);
    assign o_rsp   = '{busy: r_busy, done: r_done};

endmodule

// ----- rtl/apcl_seq.sv -----
// Control law sequencer: velocity filter, curve, floor and damping over a shared divider.
module apcl_seq #(
    parameter int unsigned DivW = apcl_pkg::DefDivW
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  apcl_pkg::t_cfg         i_cfg,
    input  logic                   i_start,
    input  apcl_pkg::t_in_beat     i_beat,
    output logic                   o_done,
    output apcl_pkg::t_out_beat    o_res,
    output apcl_pkg::t_div_req     o_div_req,
    output logic signed [DivW-1:0] o_div_num,
    output logic [DivW-1:0]        o_div_den,
    input  apcl_pkg::t_div_rsp     i_div_rsp,
    input  logic signed [DivW-1:0] i_div_quo
);
    import apcl_pkg::*;

    typedef enum logic [14:0] {
        S_IDLE = 15'b000000000000001,
        S_CLS  = 15'b000000000000010,
        S_RAW  = 15'b000000000000100,
        S_SPD  = 15'b000000000001000,
        S_EDIV = 15'b000000000010000,
        S_MDIV = 15'b000000000100000,
        S_SQ   = 15'b000000001000000,
        S_CDIV = 15'b000000010000000,
        S_LAW  = 15'b000000100000000,
        S_FLR  = 15'b000001000000000,
        S_GDIV = 15'b000010000000000,
        S_DAMP = 15'b000100000000000,
        S_DDIV = 15'b001000000000000,
        S_OUT  = 15'b010000000000000,
        S_WAIT = 15'b100000000000000
    } t_state;

    t_state r_st, r_ret;

    logic signed [PosW-1:0]  r_last_tgt, r_last_pos;
    logic [TimeW-1:0]        r_last_time;
    logic signed [SpdW-1:0]  r_spd;
    logic                    r_primed;

    logic signed [PosW:0]    r_d;
    logic [PosW:0]           r_ad;
    logic signed [8:0]       r_h;
    logic signed [31:0]      r_e;
    logic [8:0]              r_m;
    logic [17:0]             r_sq;
    logic signed [40:0]      r_sg;
    logic signed [31:0]      r_o;
    logic signed [7:0]       r_pw;
    logic                    r_brake, r_done, r_go;
    logic signed [DivW-1:0]  r_num;
    logic [DivW-1:0]         r_den;

    logic signed [7:0]       w_man;
    logic signed [PosW:0]    w_lb;
    logic                    w_bypass;
    logic signed [7:0]       w_bpw;
    logic                    w_bbrake;
    logic [TimeW-1:0]        w_dt;
    logic signed [SpdW:0]    w_rawc;
    logic [8:0]              w_q256;
    logic [8:0]              w_g;
    logic [9:0]              w_cf;
    logic signed [8:0]       w_dmax, w_dmin;
    logic signed [18:0]      w_pc, w_pf;
    logic signed [35:0]      w_ge, w_h256, w_up, w_dn, w_dlim;
    logic signed [31:0]      w_law, w_fl, w_dmp, w_oc, w_ocl;
    logic [14:0]             w_omag;
    logic [7:0]              w_pmag;
    logic signed [7:0]       w_pround;

    assign w_man = (i_beat.manual_power == -8'sd128) ? -8'sd127 : i_beat.manual_power;
    assign w_lb  = (PosW+1)'(i_cfg.lower) + $signed({1'b0, {(PosW-16){1'b0}}, i_cfg.band});
    assign w_dt  = i_beat.time_ms - r_last_time;

    always_comb begin
        w_bypass = 1'b1;
        w_bpw    = '0;
        w_bbrake = 1'b0;
        if (i_beat.sensor_fault) begin
        end else if (i_beat.manual_coast) begin
            w_bbrake = (i_beat.position_cd <= i_cfg.lower);
        end else if (w_man != 0) begin
            if (!((w_man > 0 && i_beat.position_cd >= i_cfg.upper) ||
                  (w_man < 0 && i_beat.position_cd <= i_cfg.lower)))
                w_bpw = w_man;
        end else if (!i_cfg.hold_en) begin
        end else if (i_beat.target_cd <= i_cfg.lower &&
                     (PosW+1)'(i_beat.position_cd) <= w_lb) begin
        end else begin
            w_bypass = 1'b0;
        end
    end

    // raw speed from divider, saturated to 32 bits
    always_comb begin
        logic signed [DivW-1:0] q;
        q = i_div_quo;
        if (q > DivW'(64'sh7fffffff))       w_rawc = (SpdW+1)'(33'sh07fffffff);
        else if (q < -DivW'(64'sh80000000)) w_rawc = -(SpdW+1)'(33'sh080000000);
        else                                w_rawc = (SpdW+1)'(q);
    end

    assign w_q256 = (i_div_quo > DivW'(256)) ? 9'd256 : i_div_quo[8:0];
    assign w_g    = 9'd256 - w_q256;
    assign w_cf   = 10'd768 - {r_m, 1'b0};

    assign w_dmax = $signed({2'b0, i_cfg.maxmove}) - r_h;
    assign w_dmin = $signed({2'b0, i_cfg.minmove}) - r_h;
    assign w_pc   = 19'(w_dmax) * 19'($signed({1'b0, w_q256}));
    assign w_pf   = 19'(w_dmin) * 19'($signed({1'b0, w_q256}));
    assign w_ge   = 36'(r_e) * 36'($signed({1'b0, i_cfg.gain}));
    assign w_h256 = 36'(r_h) * 36'sd256;
    assign w_up   = w_h256 + 36'(w_pc);
    assign w_dn   = w_h256 + w_ge;
    assign w_dlim = -(36'($signed({1'b0, i_cfg.maxmove})) * 36'sd256);
    assign w_law  = (r_d >= 0) ? 32'(w_up) : ((w_dn < w_dlim) ? 32'(w_dlim) : 32'(w_dn));
    assign w_fl   = 32'(w_h256) + 32'(w_pf);

    assign w_dmp = (i_div_quo > DivW'(35*256)) ? 32'sd8960 :
                   (i_div_quo < -DivW'(35*256)) ? -32'sd8960 : 32'(i_div_quo);
    assign w_oc  = r_o - w_dmp;
    assign w_ocl = (w_oc > 32'sd32512) ? 32'sd32512 :
                   (w_oc < -32'sd32512) ? -32'sd32512 : w_oc;
    assign w_omag   = w_ocl[31] ? 15'(-w_ocl) : 15'(w_ocl);
    assign w_pmag   = 8'((16'(w_omag) + 16'd128) >> 8);
    assign w_pround = w_ocl[31] ? -$signed(w_pmag) : $signed(w_pmag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_ret <= S_IDLE;
            r_done <= 1'b0;
            r_go <= 1'b0;
            r_primed <= 1'b0;
            r_last_tgt <= '0;
            r_last_pos <= '0;
            r_last_time <= '0;
            r_spd <= '0;
        end else begin
            r_done <= 1'b0;
            r_go   <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (i_start) begin
                        r_d  <= (PosW+1)'(i_beat.target_cd) - (PosW+1)'(i_beat.position_cd);
                        r_ad <= (i_beat.target_cd >= i_beat.position_cd)
                              ? (PosW+1)'(i_beat.target_cd) - (PosW+1)'(i_beat.position_cd)
                              : (PosW+1)'(i_beat.position_cd) - (PosW+1)'(i_beat.target_cd);
                        r_h  <= (i_beat.target_cd > 0) ? $signed({2'b0, i_cfg.hold}) : '0;
                        if (w_bypass) begin
                            r_pw <= w_bpw;
                            r_brake <= w_bbrake;
                            r_primed <= 1'b0;
                            r_done <= 1'b1;
                        end else begin
                            r_brake <= 1'b0;
                            r_st <= S_CLS;
                        end
                    end
                end
                S_CLS: begin
                    if (!r_primed || i_beat.target_cd != r_last_tgt) begin
                        r_last_tgt <= i_beat.target_cd;
                        r_last_pos <= i_beat.position_cd;
                        r_last_time <= i_beat.time_ms;
                        r_spd <= '0;
                        r_primed <= 1'b1;
                        r_st <= S_EDIV;
                    end else if (w_dt != 0) begin
                        r_num <= DivW'(((PosW+1)'(i_beat.position_cd) - (PosW+1)'(r_last_pos)))
                                 * DivW'(2560);
                        r_den <= DivW'(w_dt);
                        r_go  <= 1'b1;
                        r_ret <= S_RAW;
                        r_st  <= S_WAIT;
                    end else begin
                        r_st <= S_EDIV;
                    end
                end
                S_RAW: begin
                    r_num <= DivW'(w_rawc - (SpdW+1)'(r_spd));
                    r_den <= DivW'(5);
                    r_go  <= 1'b1;
                    r_ret <= S_SPD;
                    r_st  <= S_WAIT;
                end
                S_SPD: begin
                    r_spd <= r_spd + SpdW'(i_div_quo);
                    r_last_pos <= i_beat.position_cd;
                    r_last_time <= i_beat.time_ms;
                    r_st <= S_EDIV;
                end
                S_EDIV: begin
                    r_num <= DivW'(r_d) * DivW'(256);
                    r_den <= DivW'(100);
                    r_go  <= 1'b1;
                    r_ret <= S_MDIV;
                    r_st  <= S_WAIT;
                end
                S_MDIV: begin
                    r_e   <= 32'(i_div_quo);
                    r_num <= $signed(DivW'(r_ad)) * DivW'(256);
                    r_den <= DivW'(10000);
                    r_go  <= 1'b1;
                    r_ret <= S_SQ;
                    r_st  <= S_WAIT;
                end
                S_SQ: begin
                    r_m  <= w_q256;
                    r_sq <= 18'(w_q256) * 18'(w_q256);
                    r_st <= S_CDIV;
                end
                S_CDIV: begin
                    r_num <= DivW'(28'(r_sq) * 28'(w_cf));
                    r_den <= DivW'(65536);
                    r_go  <= 1'b1;
                    r_ret <= S_LAW;
                    r_st  <= S_WAIT;
                end
                S_LAW: begin
                    r_o <= w_law;
                    if (r_d > 0) begin
                        r_num <= DivW'(r_d) * DivW'(256);
                        r_den <= DivW'(1200);
                        r_go  <= 1'b1;
                        r_ret <= S_FLR;
                        r_st  <= S_WAIT;
                    end else begin
                        r_st <= S_GDIV;
                    end
                end
                S_FLR: begin
                    if (w_fl > r_o) r_o <= w_fl;
                    r_st <= S_GDIV;
                end
                S_GDIV: begin
                    r_num <= $signed(DivW'(r_ad)) * DivW'(256);
                    r_den <= DivW'(3500);
                    r_go  <= 1'b1;
                    r_ret <= S_DAMP;
                    r_st  <= S_WAIT;
                end
                S_DAMP: begin
                    r_sg <= 41'(r_spd) * 41'($signed({1'b0, w_g}));
                    r_st <= S_DDIV;
                end
                S_DDIV: begin
                    r_num <= DivW'(r_sg) * DivW'(45);
                    r_den <= DivW'(25600);
                    r_go  <= 1'b1;
                    r_ret <= S_OUT;
                    r_st  <= S_WAIT;
                end
                S_OUT: begin
                    r_pw   <= w_pround;
                    r_done <= 1'b1;
                    r_st   <= S_IDLE;
                end
                S_WAIT: begin
                    if (i_div_rsp.done) r_st <= r_ret;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_div_req = '{start: r_go};
    assign o_div_num = r_num;
    assign o_div_den = r_den;
    assign o_done    = r_done;
    assign o_res     = '{motor_power: r_pw, brake_hold: r_brake};

endmodule

// ----- rtl/arm_position_control_loop.sv -----
// Top level of the arm position control loop: handshake, configuration and result register.
// One tick in, one result out. A fault, coast, manual, holding-disabled or rest-band tick
// has its result valid once the start strobe, the sequencer done flag and the output valid
// register have been set in turn. A tick under the automatic law walks a sequencer that
// runs up to eight divisions on one bit-serial divider of DivW bits, one quotient bit per
// cycle, before its result is valid. The next tick is accepted once the result beat has
// been taken and the sequencer is idle.
module arm_position_control_loop #(
    parameter int unsigned DivW = apcl_pkg::DefDivW
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    apcl_if.sink                          s_in,
    apcl_if.source                        m_out,
    input  logic                          i_cfg_we,
    input  logic [apcl_pkg::IdxW-1:0]     i_cfg_idx,
    input  logic [apcl_pkg::CfgW-1:0]     i_cfg_data
);
    import apcl_pkg::*;

    t_cfg               r_cfg;
    t_in_beat           r_beat;
    logic               r_busy;
    logic               r_ovalid;
    t_out_beat          r_obeat;
    logic               w_done;
    t_out_beat          w_res;
    t_div_req           w_req;
    t_div_rsp           w_rsp;
    logic signed [DivW-1:0] w_num, w_quo;
    logic [DivW-1:0]    w_den;
    logic               r_start;

    assign s_in.ready = !r_busy && !r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{lower: '0, upper: 24'sd18000, band: 16'd100, hold_en: 1'b1,
                       hold: 7'd15, minmove: 7'd60, maxmove: 7'd85, gain: 7'd4};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LOWER:   r_cfg.lower   <= i_cfg_data;
                REG_UPPER:   r_cfg.upper   <= i_cfg_data;
                REG_BAND:    r_cfg.band    <= i_cfg_data[15:0];
                REG_HOLD_EN: r_cfg.hold_en <= i_cfg_data[0];
                REG_HOLD:    r_cfg.hold    <= i_cfg_data[6:0];
                REG_MINMOVE: r_cfg.minmove <= i_cfg_data[6:0];
                REG_MAXMOVE: r_cfg.maxmove <= i_cfg_data[6:0];
                REG_GAIN:    r_cfg.gain    <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
            r_start  <= 1'b0;
        end else begin
            r_start <= s_in.valid && s_in.ready;
            if (s_in.valid && s_in.ready) r_busy <= 1'b1;
            if (w_done) begin
                r_busy   <= 1'b0;
                r_ovalid <= 1'b1;
            end else if (m_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_in.valid && s_in.ready) r_beat <= s_in.payload;
        if (w_done) r_obeat <= w_res;
    end

    apcl_seq #(.DivW(DivW)) u_seq (
        .i_clk, .i_rst_n, .i_cfg(r_cfg), .i_start(r_start), .i_beat(r_beat),
        .o_done(w_done), .o_res(w_res), .o_div_req(w_req), .o_div_num(w_num),
        .o_div_den(w_den), .i_div_rsp(w_rsp), .i_div_quo(w_quo)
    );

    apcl_div #(.DivW(DivW)) u_div (
        .i_clk, .i_rst_n, .i_req(w_req), .i_num(w_num), .i_den(w_den),
        .o_rsp(w_rsp), .o_quo(w_quo)
    );

    assign m_out.valid   = r_ovalid;
    assign m_out.payload = r_obeat;

endmodule

// ----- rtl/apcl_chk.sv -----
// Port checker for the arm position control loop, bound to the top level.
module apcl_chk (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input apcl_pkg::t_out_beat  i_out
);
    import apcl_pkg::*;

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out.motor_power != -8'sd128)
        else $error("power out of range");
    a_brake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out.brake_hold |-> i_out.motor_power == 8'sd0)
        else $error("brake with power");
    a_noacc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("accept while result pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out))
        else $error("result changed while stalled");
endmodule

bind arm_position_control_loop apcl_chk u_chk (
    .i_clk, .i_rst_n,
    .i_in_valid(s_in.valid), .i_in_ready(s_in.ready),
    .i_out_valid(m_out.valid), .i_out_ready(m_out.ready), .i_out(m_out.payload)
);

// ----- tb/arm_position_control_loop_tb.sv -----
// Self-checking testbench for the arm position control loop: directed and random ticks against a scoreboard.
module arm_position_control_loop_tb;
    import apcl_pkg::*;

    localparam int unsigned StallLimit = 5000;

    class arm_scoreboard;
        longint lower, upper, band, hold_en, hold, minmove, maxmove, gain;
        longint aim_prev, pos_prev, speed;
        bit [31:0] ms_prev;
        bit primed;
        t_out_beat power_q[$];
        int unsigned errors;

        function new();
            lower = 0; upper = 18000; band = 100; hold_en = 1;
            hold = 15; minmove = 60; maxmove = 85; gain = 4;
            aim_prev = 0; pos_prev = 0; speed = 0; ms_prev = 0; primed = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [IdxW-1:0] idx, logic [CfgW-1:0] v);
            case (idx)
                REG_LOWER:   lower = longint'($signed(v));
                REG_UPPER:   upper = longint'($signed(v));
                REG_BAND:    band = v[15:0];
                REG_HOLD_EN: hold_en = v[0];
                REG_HOLD:    hold = v[6:0];
                REG_MINMOVE: minmove = v[6:0];
                REG_MAXMOVE: maxmove = v[6:0];
                REG_GAIN:    gain = v[6:0];
                default: ;
            endcase
        endfunction

        function longint rdiv(longint n, longint d);
            if (n >= 0) return (n + d / 2) / d;
            return -((-n + d / 2) / d);
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function void note_tick(t_in_beat b);
            longint pos, aim, man, pwr, d, ad, e, m, c, h, o, f, g, damp, raw;
            bit [31:0] dt;
            t_out_beat r;
            pos = longint'($signed(b.position_cd));
            aim = longint'($signed(b.target_cd));
            man = longint'($signed(b.manual_power));
            pwr = 0;
            r.brake_hold = 1'b0;
            if (man < -127) man = -127;
            if (b.sensor_fault) begin
                primed = 0;
            end else if (b.manual_coast) begin
                if (pos <= lower) r.brake_hold = 1'b1;
                primed = 0;
            end else if (man != 0) begin
                if (!((man > 0 && pos >= upper) || (man < 0 && pos <= lower))) pwr = man;
                primed = 0;
            end else if (hold_en == 0) begin
                primed = 0;
            end else if (aim <= lower && pos <= lower + band) begin
                primed = 0;
            end else begin
                d = aim - pos;
                ad = d < 0 ? -d : d;
                if (!primed || aim != aim_prev) begin
                    aim_prev = aim; pos_prev = pos; ms_prev = b.time_ms;
                    speed = 0; primed = 1;
                end else begin
                    dt = b.time_ms - ms_prev;
                    if (dt != 0) begin
                        raw = rdiv((pos - pos_prev) * 2560, longint'(dt));
                        raw = clip(raw, -64'sd2147483648, 64'sd2147483647);
                        speed += rdiv(raw - speed, 5);
                        pos_prev = pos; ms_prev = b.time_ms;
                    end
                end
                h = aim > 0 ? hold : 0;
                e = rdiv(d * 256, 100);
                m = rdiv(ad * 256, 10000);
                if (m > 256) m = 256;
                c = rdiv(m * m * (768 - 2 * m), 65536);
                if (d >= 0) begin
                    o = h * 256 + (maxmove - h) * c;
                end else begin
                    o = h * 256 + gain * e;
                    if (o < -maxmove * 256) o = -maxmove * 256;
                end
                if (d > 0) begin
                    f = rdiv(d * 256, 1200);
                    if (f > 256) f = 256;
                    if (h * 256 + (minmove - h) * f > o) o = h * 256 + (minmove - h) * f;
                end
                g = 256 - rdiv(ad * 256, 3500);
                if (g < 0) g = 0;
                damp = clip(rdiv(45 * speed * g, 25600), -35 * 256, 35 * 256);
                o = clip(o - damp, -127 * 256, 127 * 256);
                pwr = rdiv(o, 256);
            end
            r.motor_power = pwr[7:0];
            power_q.push_back(r);
        endfunction

        function void check_result(t_out_beat act);
            t_out_beat exp_r;
            if (power_q.size() == 0) begin
                $error("result beat with no expectation waiting");
                errors++;
                return;
            end
            exp_r = power_q.pop_front();
            if (act.motor_power !== exp_r.motor_power) begin
                $error("motor_power expected %0d actual %0d", exp_r.motor_power, act.motor_power);
                errors++;
            end
            if (act.brake_hold !== exp_r.brake_hold) begin
                $error("brake_hold expected %0d actual %0d", exp_r.brake_hold, act.brake_hold);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [IdxW-1:0] i_cfg_idx;
    logic [CfgW-1:0] i_cfg_data;

    apcl_if #(.t_payload(t_in_beat))  tick_ch ();
    apcl_if #(.t_payload(t_out_beat)) power_ch ();

    arm_position_control_loop uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .s_in       (tick_ch),
        .m_out      (power_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    arm_scoreboard sb = new();
    bit [31:0] clock_ms;
    int unsigned burst_left;
    int unsigned idle_cycles;
    int unsigned stall_left;
    bit stall_on;

    always begin
        i_clk = 1'b1; #6;
        i_clk = 1'b0; #6;
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_LOWER;
        i_cfg_data = '0;
        tick_ch.valid = 1'b0;
        tick_ch.payload = '0;
        power_ch.ready = 1'b0;
    end

    // receiver stall pattern: runs of ready and stall, some long runs without stalls
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_on <= ($urandom_range(0, 2) == 0);
            stall_left <= $urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 12);
            power_ch.ready <= 1'b1;
        end else begin
            stall_left <= stall_left - 1;
            power_ch.ready <= !stall_on || ($urandom_range(0, 3) == 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && power_ch.valid && power_ch.ready) sb.check_result(power_ch.payload);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (tick_ch.valid && tick_ch.ready) || (power_ch.valid && power_ch.ready)
            || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= StallLimit) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_reg(logic [IdxW-1:0] idx, logic [CfgW-1:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        sb.set_reg(idx, v);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        @(negedge i_clk);
        tick_ch.valid <= 1'b0;
        while (sb.power_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic send_tick(t_in_beat b);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            if ($urandom_range(0, 2) != 0) begin
                @(negedge i_clk);
                tick_ch.valid <= 1'b0;
                repeat ($urandom_range(0, 15)) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        tick_ch.valid <= 1'b1;
        tick_ch.payload <= b;
        do @(posedge i_clk); while (!tick_ch.ready);
        sb.note_tick(b);
    endtask

    function automatic t_in_beat auto_tick(int pos, int aim);
        t_in_beat b;
        b = '0;
        b.position_cd = PosW'(pos);
        b.target_cd = PosW'(aim);
        b.time_ms = clock_ms;
        return b;
    endfunction

    function automatic t_in_beat noise_tick();
        t_in_beat b;
        b.position_cd = PosW'($urandom);
        b.sensor_fault = 1'($urandom_range(0, 1));
        b.target_cd = PosW'($urandom);
        b.manual_power = 8'($urandom);
        b.manual_coast = 1'($urandom_range(0, 1));
        b.time_ms = $urandom;
        return b;
    endfunction

    task automatic run_directed();
        t_in_beat b;
        b = auto_tick(5000, 9000); b.sensor_fault = 1'b1; send_tick(b);
        b = auto_tick(-5, 9000); b.manual_coast = 1'b1; send_tick(b);
        b = auto_tick(500, 9000); b.manual_coast = 1'b1; send_tick(b);
        b = auto_tick(18000, 0); b.manual_power = 8'sd127; send_tick(b);
        b = auto_tick(17999, 0); b.manual_power = 8'sd127; send_tick(b);
        b = auto_tick(0, 0); b.manual_power = -8'sd50; send_tick(b);
        b = auto_tick(3000, 0); b.manual_power = -8'sd128; send_tick(b);
        b = auto_tick(100, 0); send_tick(b);
        b = auto_tick(101, 0); send_tick(b);
        b = auto_tick(-8388608, 8388607); send_tick(b);
        b = auto_tick(8388607, -8388608); send_tick(b);
        b = auto_tick(2000, 9000); send_tick(b);
        b = auto_tick(2300, 9000); send_tick(b);
        b = auto_tick(2600, 9000); send_tick(b);
        clock_ms += 10;
        b = auto_tick(2900, 9000); send_tick(b);
        clock_ms += 10;
        b = auto_tick(9100, 9000); send_tick(b);
        clock_ms = 32'hFFFF_FFF0;
        b = auto_tick(9000, 9000); send_tick(b);
        clock_ms += 32;
        b = auto_tick(8950, 9000); send_tick(b);
        b = auto_tick(-3000, -2000); send_tick(b);
        clock_ms += 5;
        b = auto_tick(-1000, -2000); send_tick(b);
    endtask

    task automatic run_random(int unsigned n);
        t_in_beat b;
        int pos, aim, len;
        int unsigned sent;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(0, 9) == 0) begin
                send_tick(noise_tick());
                sent++;
            end else begin
                case ($urandom_range(0, 5))
                    0: aim = $urandom_range(0, 400) - 200;
                    1: aim = int'($urandom) >>> 8;
                    default: aim = $urandom_range(0, 22000) - 2000;
                endcase
                pos = aim + $urandom_range(0, 12000) - 6000;
                len = $urandom_range(4, 30);
                for (int k = 0; k < len; k++) begin
                    clock_ms += ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 25);
                    pos += (aim - pos) / $urandom_range(2, 8) + $urandom_range(0, 200) - 100;
                    b = auto_tick(pos, aim);
                    case ($urandom_range(0, 19))
                        0: b.sensor_fault = 1'b1;
                        1: b.manual_coast = 1'b1;
                        2: b.manual_power = 8'($urandom);
                        3: b.target_cd = PosW'(aim + 1);
                        default: ;
                    endcase
                    send_tick(b);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        clock_ms = 1000;
        burst_left = 0;
        stall_left = 0;
        stall_on = 0;
        idle_cycles = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        run_random(250);
        drain();

        write_reg(REG_LOWER, 24'h800000);
        write_reg(REG_UPPER, 24'h7FFFFF);
        write_reg(REG_BAND, 24'd65535);
        write_reg(REG_HOLD, 24'd127);
        write_reg(REG_MINMOVE, 24'd127);
        write_reg(REG_MAXMOVE, 24'd127);
        write_reg(REG_GAIN, 24'd127);
        run_random(250);
        drain();

        write_reg(REG_LOWER, 24'd500);
        write_reg(REG_UPPER, 24'd12000);
        write_reg(REG_BAND, 24'd0);
        write_reg(REG_HOLD, 24'd0);
        write_reg(REG_MINMOVE, 24'd0);
        write_reg(REG_MAXMOVE, 24'd0);
        write_reg(REG_GAIN, 24'd0);
        run_random(250);
        drain();

        write_reg(REG_HOLD_EN, 24'd0);
        run_random(120);
        drain();

        write_reg(REG_HOLD_EN, 24'd1);
        write_reg(REG_LOWER, 24'd15000);
        write_reg(REG_UPPER, 24'd1000);
        write_reg(REG_BAND, 24'd3000);
        write_reg(REG_HOLD, 24'd40);
        write_reg(REG_MINMOVE, 24'd20);
        write_reg(REG_MAXMOVE, 24'd100);
        write_reg(REG_GAIN, 24'd9);
        run_random(250);
        drain();

        for (int ph = 0; ph < 2; ph++) begin
            write_reg(REG_LOWER, CfgW'($urandom_range(0, 4000) - 2000));
            write_reg(REG_UPPER, CfgW'($urandom_range(10000, 25000)));
            write_reg(REG_BAND, CfgW'($urandom_range(0, 65535)));
            write_reg(REG_HOLD, CfgW'($urandom_range(0, 127)));
            write_reg(REG_MINMOVE, CfgW'($urandom_range(0, 127)));
            write_reg(REG_MAXMOVE, CfgW'($urandom_range(0, 127)));
            write_reg(REG_GAIN, CfgW'($urandom_range(0, 127)));
            run_random(200);
            drain();
        end

        repeat (400) @(posedge i_clk);
        if (sb.errors == 0 && sb.power_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            if (sb.power_q.size() != 0) $error("%0d results never arrived", sb.power_q.size());
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
